FILE: hw/rtl/qpht_pkg.sv
// Package for the quadratic-probe hash table core.
// Holds the table size, command, status and bucket-state codes and the queue entry type.
// Depends on nothing.
`default_nettype none
package qpht_pkg;
   // Table size; probe indexing takes the low hash bits, so keep it a power of two.
   localparam int CAPACITY = 256;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;
   localparam logic [1:0] CMD_SET    = 2'd3;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   localparam logic [1:0] BKT_EMPTY   = 2'd0;
   localparam logic [1:0] BKT_ACTIVE  = 2'd1;
   localparam logic [1:0] BKT_DELETED = 2'd2;
   localparam logic [1:0] BKT_MASK    = 2'h3;

   typedef struct packed {
      logic [1:0]  command;
      logic        stop_at_empty;
      logic [31:0] key_hash;
      logic [31:0] key;
      logic [31:0] value_in;
   } op_type;
endpackage
`default_nettype wire

FILE: hw/rtl/qpht_front.sv
// Front end: accepts requests, classifies them and queues them (two entries).
// Depends on qpht_pkg.
`default_nettype none
module qpht_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire [1:0]            req_command,
   input  wire [31:0]           req_key_hash,
   input  wire [31:0]           req_key,
   input  wire [31:0]           req_value_in,
   output logic                 op_valid,
   input  wire                  op_ready,
   output qpht_pkg::op_type     op_data
);
   import qpht_pkg::*;

   op_type     q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push, pop;
   op_type     entry;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign op_valid  = (cnt_ff != 2'd0);
   assign pop       = op_valid && op_ready;
   assign op_data   = q_ff[rp_ff];

   always_comb begin
      entry.command       = req_command;
      entry.stop_at_empty = (req_command == CMD_LOOKUP);
      entry.key_hash      = req_key_hash;
      entry.key           = req_key;
      entry.value_in      = req_value_in;
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= entry;
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count step");
endmodule
`default_nettype wire

FILE: hw/rtl/qpht_back.sv
// Back end: walks the quadratic probe sequence over bucket memories.
// Depends on qpht_pkg.
`default_nettype none
module qpht_back #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  op_valid,
   output logic                 op_ready,
   input  qpht_pkg::op_type     op_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_value_out,
   output logic [7:0]           rsp_slot,
   output logic [8:0]           rsp_entry_total,
   output logic                 clearing
);
   import qpht_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int IW = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [1:0]            bst_mem [CAPACITY];
   logic [KEY_BITS-1:0]   key_mem [CAPACITY];
   logic [VALUE_BITS-1:0] val_mem [CAPACITY];

   logic [2:0]      st_ff, st_in;
   op_type          op_ff;
   logic [IW-1:0]   i_ff, i_in;
   logic [AW-1:0]   sq_ff, sq_in;     // i*i mod CAPACITY, kept incrementally
   logic [AW-1:0]   ix_ff;
   logic [AW-1:0]   clr_ff;
   logic [1:0]      bst_rd_ff;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [8:0]      count_ff;
   logic [1:0]      status_ff, status_in;
   logic [31:0]     vout_ff, vout_in;
   logic [7:0]      slot_ff, slot_in;
   logic            rvalid_ff;

   logic [AW-1:0]   probe;
   logic [AW-1:0]   hash_lo;
   logic [KEY_BITS-1:0] key_m;
   logic [VALUE_BITS-1:0] val_m;
   logic [1:0]      bst;
   logic            hit, last, stop_e, free;

   assign hash_lo = op_ff.key_hash[AW-1:0];
   assign probe   = hash_lo + sq_ff;
   assign key_m   = KEY_BITS'(op_ff.key);
   assign val_m   = VALUE_BITS'(op_ff.value_in);
   assign bst     = bst_rd_ff & BKT_MASK;
   assign hit     = (bst == BKT_ACTIVE) && (key_rd_ff == key_m);
   assign free    = (bst != BKT_ACTIVE);
   assign stop_e  = op_ff.stop_at_empty && (bst == BKT_EMPTY);
   assign last    = (i_ff == IW'(CAPACITY - 1));

   assign op_ready = (st_ff == S_IDLE) && !rvalid_ff;
   assign clearing = (st_ff == S_CLEAR);
   assign rsp_valid       = rvalid_ff;
   assign rsp_status      = status_ff;
   assign rsp_value_out   = vout_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_entry_total = count_ff;

   always_comb begin
      st_in = st_ff;
      i_in  = i_ff;
      sq_in = sq_ff;
      case (st_ff)
         S_CLEAR: if (clr_ff == AW'(CAPACITY - 1)) st_in = S_IDLE;
         S_IDLE: begin
            i_in  = '0;
            sq_in = '0;
            if (op_valid && op_ready) st_in = S_READ;
         end
         S_READ: st_in = S_EVAL;
         S_EVAL: begin
            // advance: (i+1)^2 = i^2 + 2i + 1
            if ((op_ff.command == CMD_INSERT ? free : hit) || stop_e || last) begin
               st_in = S_RESP;
            end else begin
               sq_in = sq_ff + AW'({i_ff, 1'b1});
               i_in  = i_ff + IW'(1);
               st_in = S_READ;
            end
         end
         S_RESP: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   // Response fields for the probe being finished.
   always_comb begin
      status_in = (op_ff.command == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
      vout_in   = '0;
      slot_in   = '0;
      case (op_ff.command)
         CMD_INSERT: if (free) begin
            status_in = ST_DONE;
            slot_in   = 8'(ix_ff);
         end
         CMD_LOOKUP: if (hit) begin
            status_in = ST_DONE;
            vout_in   = 32'(val_rd_ff);
            slot_in   = 8'(ix_ff);
         end
         default: if (hit) begin
            status_in = ST_DONE;
            slot_in   = 8'(ix_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_CLEAR) bst_mem[clr_ff] <= BKT_EMPTY;
      if (st_ff == S_READ) ix_ff <= probe;
      if (st_ff == S_READ) begin
         bst_rd_ff <= bst_mem[probe];
         key_rd_ff <= key_mem[probe];
         val_rd_ff <= val_mem[probe];
      end
      if (st_ff == S_IDLE && op_valid && op_ready) op_ff <= op_data;
      if (st_ff == S_EVAL && st_in == S_RESP) begin
         status_ff <= status_in;
         vout_ff   <= vout_in;
         slot_ff   <= slot_in;
         case (op_ff.command)
            CMD_INSERT: if (free) begin
               bst_mem[ix_ff] <= BKT_ACTIVE;
               key_mem[ix_ff] <= key_m;
               val_mem[ix_ff] <= val_m;
            end
            CMD_DELETE: if (hit) bst_mem[ix_ff] <= BKT_DELETED;
            CMD_SET: if (hit) val_mem[ix_ff] <= val_m;
            default: ;
         endcase
      end
      if (reset) begin
         st_ff     <= S_CLEAR;
         clr_ff    <= '0;
         i_ff      <= '0;
         sq_ff     <= '0;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         i_ff   <= i_in;
         sq_ff  <= sq_in;
         if (st_ff == S_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (st_ff == S_EVAL && st_in == S_RESP) begin
            if (op_ff.command == CMD_INSERT && free) count_ff <= count_ff + 9'd1;
            else if (op_ff.command == CMD_DELETE && hit && count_ff != 9'd0)
               count_ff <= count_ff - 9'd1;
         end
         if (st_ff == S_RESP) rvalid_ff <= 1'b1;
         else if (rsp_ready) rvalid_ff <= 1'b0;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      op_ready |-> st_ff == S_IDLE) else $error("ready outside idle");
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_CLEAR |-> !rvalid_ff) else $error("response during clear");
   a_rsp_after: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_RESP |=> rvalid_ff) else $error("response lost");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 9'(CAPACITY)) else $error("count above capacity");
endmodule
`default_nettype wire

FILE: hw/rtl/quadratic_probe_hash_table_core.sv
// Top level of the quadratic-probe hash table: front queue plus probe engine.
// Depends on qpht_pkg, qpht_front and qpht_back.
//
// Use: send a request (command, key_hash, key, value_in) on req_valid/ready;
// one response (status, value_out, slot, entry_total) returns on rsp_*.
// Commands: lookup, insert, delete, set value. The hash is precomputed.
// The front queues up to two requests so the sender can run ahead of the
// probe engine. The engine walks slot = (hash + i*i) mod CAPACITY with the
// square kept by a running add; each probe is a memory read, then an
// evaluate step, for at most CAPACITY probes, then a response state; one
// request is in the engine at a time.
// Lookup stops at an empty bucket; delete and set walk the whole sequence
// when the key is absent, so a miss walks all CAPACITY probes.
// Reset: a clearing pass marks every bucket empty; no
// request is accepted into the engine until it ends (the queue still fills).
// When the receiver stalls, the response holds in its register and the
// engine takes no new request until it is delivered.
`default_nettype none
module quadratic_probe_hash_table_core #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire [1:0]   req_command,
   input  wire [31:0]  req_key_hash,
   input  wire [31:0]  req_key,
   input  wire [31:0]  req_value_in,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_value_out,
   output logic [7:0]  rsp_slot,
   output logic [8:0]  rsp_entry_total
);
   import qpht_pkg::*;

   op_type op_data;
   logic   op_valid, op_ready, clearing;

   qpht_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_command, .req_key_hash,
      .req_key, .req_value_in, .op_valid, .op_ready, .op_data
   );

   qpht_back #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS))
   u_back (
      .clock, .reset, .op_valid, .op_ready, .op_data, .rsp_valid, .rsp_ready,
      .rsp_status, .rsp_value_out, .rsp_slot, .rsp_entry_total, .clearing
   );

   a_clear_hold: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !op_ready) else $error("engine took request while clearing");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL) else $error("bad status");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_value_out == '0 && rsp_slot == '0)
      else $error("miss carries data");
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for quadratic_probe_hash_table_core: directed and random requests.
// Depends on qpht_pkg and the core RTL; a scoreboard class mirrors the table.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import qpht_pkg::*;

   localparam int NUM_BUCKETS  = CAPACITY;
   localparam int RANDOM_REQS  = 330;
   localparam int IDLE_LIMIT   = 8000;
   localparam int DRAIN_CYCLES = 2 * NUM_BUCKETS + 40;
   localparam int KEY_POOL     = 12;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
      logic [7:0]  slot;
      logic [8:0]  entry_total;
   } reply_type;

   // Shadow copy of the table; predicts one reply per accepted request.
   class hash_table_scoreboard;
      logic [1:0]  bucket[NUM_BUCKETS];
      logic [31:0] keys[NUM_BUCKETS];
      logic [31:0] vals[NUM_BUCKETS];
      logic [8:0]  live;
      reply_type   pending[$];
      int          mismatches;

      function new();
         foreach (bucket[i]) bucket[i] = BKT_EMPTY;
         live = '0;
         mismatches = 0;
      endfunction

      function logic [7:0] probe(logic [31:0] hash, int i);
         logic [31:0] sum;
         sum = hash + 32'(i * i);
         return sum[7:0];
      endfunction

      // First active bucket holding key; stop_empty ends the walk at an empty one.
      function int find_key(logic [31:0] hash, logic [31:0] key, bit stop_empty);
         logic [7:0] ix;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            ix = probe(hash, i);
            if (bucket[ix] == BKT_ACTIVE && keys[ix] == key) return ix;
            if (stop_empty && bucket[ix] == BKT_EMPTY) return -1;
         end
         return -1;
      endfunction

      function void note_request(logic [1:0] cmd, logic [31:0] hash,
                                 logic [31:0] key, logic [31:0] value);
         reply_type r;
         int     hit;
         logic [7:0] ix;
         r = '{status: ST_NOTFOUND, value_out: '0, slot: '0, entry_total: '0};
         case (cmd)
            CMD_LOOKUP: begin
               hit = find_key(hash, key, 1'b1);
               if (hit >= 0) begin
                  r.status = ST_DONE;
                  r.value_out = vals[hit];
                  r.slot = hit[7:0];
               end
            end
            CMD_INSERT: begin
               r.status = ST_FULL;
               for (int i = 0; i < NUM_BUCKETS; i++) begin
                  ix = probe(hash, i);
                  if (bucket[ix] != BKT_ACTIVE) begin
                     bucket[ix] = BKT_ACTIVE;
                     keys[ix] = key;
                     vals[ix] = value;
                     live++;
                     r.status = ST_DONE;
                     r.slot = ix;
                     break;
                  end
               end
            end
            CMD_DELETE: begin
               hit = find_key(hash, key, 1'b0);
               if (hit >= 0) begin
                  bucket[hit] = BKT_DELETED;
                  if (live > 0) live--;
                  r.status = ST_DONE;
                  r.slot = hit[7:0];
               end
            end
            default: begin
               hit = find_key(hash, key, 1'b0);
               if (hit >= 0) begin
                  vals[hit] = value;
                  r.status = ST_DONE;
                  r.slot = hit[7:0];
               end
            end
         endcase
         r.entry_total = live;
         pending.push_back(r);
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected reply %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("reply mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_LOOKUP;
   logic [31:0] req_key_hash = '0;
   logic [31:0] req_key = '0;
   logic [31:0] req_value_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_value_out;
   logic [7:0]  rsp_slot;
   logic [8:0]  rsp_entry_total;

   hash_table_scoreboard table_model = new();
   int          idle_cycles = 0;
   logic [31:0] pool_keys[KEY_POOL];
   logic [31:0] pool_hashes[KEY_POOL];

   always #6 clock = ~clock;

   quadratic_probe_hash_table_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_key_hash(req_key_hash),
      .req_key(req_key), .req_value_in(req_value_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_value_out(rsp_value_out),
      .rsp_slot(rsp_slot), .rsp_entry_total(rsp_entry_total)
   );

   // Sample both handshakes at the rising edge; inputs only move on the falling edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            table_model.note_request(req_command, req_key_hash, req_key, req_value_in);
         if (rsp_valid && rsp_ready)
            table_model.check_reply('{rsp_status, rsp_value_out, rsp_slot, rsp_entry_total});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Receiver: stall at random, mostly short stretches, now and then a long one,
   // and sometimes run with ready held high.
   initial begin : receiver
      int stall;
      int run;
      @(negedge clock);
      forever begin
         run = $urandom_range(0, 9) < 3 ? $urandom_range(10, 60) : $urandom_range(0, 4);
         rsp_ready = 1'b1;
         repeat (run + 1) @(negedge clock);
         stall = $urandom_range(0, 19) == 0 ? $urandom_range(20, 80) : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // Present one request and hold it until accepted; valid drops only if a gap follows.
   task automatic send_request(logic [1:0] cmd, logic [31:0] hash,
                               logic [31:0] key, logic [31:0] value);
      int gap;
      req_valid = 1'b1;
      req_command = cmd;
      req_key_hash = hash;
      req_key = key;
      req_value_in = value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      gap = $urandom_range(0, 29) == 0 ? $urandom_range(15, 70)
          : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
      if ($urandom_range(0, 99) < 25) gap = 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin : stimulus
      int pick;
      int roll;
      logic [1:0] cmd;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, field extremes, deleted-bucket skipping, duplicates.
      send_request(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_request(CMD_INSERT, 32'h0, 32'h0, 32'h0);
      send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_request(CMD_LOOKUP, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_request(CMD_SET, 32'h0, 32'h0, 32'hA5A5_5A5A);
      send_request(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_request(CMD_SET, 32'h0, 32'h1234_5678, 32'h1);
      send_request(CMD_DELETE, 32'h0, 32'h1234_5678, 32'h0);
      // Same low hash bits: second key lands behind the first.
      send_request(CMD_INSERT, 32'h8000_0000, 32'h5555_5555, 32'h7);
      send_request(CMD_DELETE, 32'h0, 32'h0, 32'h0);
      send_request(CMD_LOOKUP, 32'h0, 32'h5555_5555, 32'h0);
      send_request(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
      // Duplicate key: delete hits the first, lookup then finds the second.
      send_request(CMD_INSERT, 32'h40, 32'hCAFE_0001, 32'h11);
      send_request(CMD_INSERT, 32'h40, 32'hCAFE_0001, 32'h22);
      send_request(CMD_DELETE, 32'h40, 32'hCAFE_0001, 32'h0);
      send_request(CMD_LOOKUP, 32'h40, 32'hCAFE_0001, 32'h0);
      // Reuse a deleted bucket.
      send_request(CMD_INSERT, 32'h0, 32'hBEEF_0000, 32'h33);
      // Fill one probe path until inserts report a full table.
      for (int i = 0; i < 50; i++)
         send_request(CMD_INSERT, 32'h0000_0090, 32'(i) ^ 32'h0F0F_0000, 32'(i));
      send_request(CMD_LOOKUP, 32'h0000_0090, 32'h0F0F_0000, 32'h0);
      send_request(CMD_DELETE, 32'h0000_0090, 32'h0F0F_0003, 32'h0);
      send_request(CMD_INSERT, 32'h0000_0090, 32'h0BAD_0BAD, 32'h44);

      // Random: a small pool of keys sharing a few probe paths, plus noise.
      for (int i = 0; i < KEY_POOL; i++) begin
         pool_keys[i] = $urandom();
         pool_hashes[i] = {24'($urandom_range(0, 32'hFF_FFFF)),
                           8'($urandom_range(0, 3) * 8)};
      end
      for (int n = 0; n < RANDOM_REQS; n++) begin
         roll = $urandom_range(0, 99);
         cmd = roll < 35 ? CMD_INSERT : roll < 65 ? CMD_LOOKUP
             : roll < 85 ? CMD_DELETE : CMD_SET;
         if ($urandom_range(0, 99) < 15) begin
            send_request(cmd, $urandom(), $urandom(), $urandom());
         end else begin
            pick = $urandom_range(0, KEY_POOL - 1);
            send_request(cmd, pool_hashes[pick], pool_keys[pick], $urandom());
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_model.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/qpht_pkg.sv
hw/rtl/qpht_front.sv
hw/rtl/qpht_back.sv
hw/rtl/quadratic_probe_hash_table_core.sv
test/tb_top.sv
